// ----- design/sws_pkg.sv -----
package sws_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 32;
  localparam int SQ_W       = 48;
  localparam int OUT_W      = 24;
  localparam int WORK_W     = 64;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = ROOT_W + 1;
  localparam int DIV_STEPS  = WORK_W;
  localparam int SQRT_STEPS = WORK_W / 2;
  localparam int CNT_W      = 6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] max_value;
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [OUT_W-1:0]    mean_q8;
    logic        [OUT_W-1:0]    rms_q8;
  } result_t;

  // Window totals handed from the accumulator to the divide/root engine.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] max_value;
    logic signed [SAMPLE_W-1:0] min_value;
    logic        [SUM_W-1:0]    sum;
    logic        [SQ_W-1:0]     sq_sum;
  } acc_t;

endpackage

// ----- design/sws_accum.sv -----
module sws_accum
  import sws_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_sample,
  output acc_t                       totals
);

  logic signed [SAMPLE_W-1:0] running_max;
  logic signed [SAMPLE_W-1:0] running_min;
  logic        [SUM_W-1:0]    running_sum;
  logic        [SQ_W-1:0]     running_square_sum;
  logic                       window_empty;

  logic signed [2*SAMPLE_W-1:0] square;

  always_comb begin
    square = sample * sample;
    if (window_empty) begin
      totals.max_value = sample;
      totals.min_value = sample;
    end else begin
      totals.max_value = (sample > running_max) ? sample : running_max;
      totals.min_value = (sample < running_min) ? sample : running_min;
    end
    totals.sum    = running_sum + SUM_W'(sample);
    totals.sq_sum = running_square_sum + SQ_W'($unsigned(square));
  end

  // Fold the sample in; on the closing sample hand off and clear.
  always_ff @(posedge clk) begin
    if (rst || (en && last_sample)) begin
      running_max        <= '0;
      running_min        <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      window_empty       <= 1'b1;
    end else if (en) begin
      running_max        <= totals.max_value;
      running_min        <= totals.min_value;
      running_sum        <= totals.sum;
      running_square_sum <= totals.sq_sum;
      window_empty       <= 1'b0;
    end
  end

endmodule

// ----- design/sws_sub.sv -----
module sws_sub #(
  parameter int W = 35
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] full;

  always_comb begin
    full = {1'b0, a} - {1'b0, b};
    diff = full[W-1:0];
    ge   = ~full[W];
  end

endmodule

// ----- design/sws_engine.sv -----
module sws_engine
  import sws_pkg::*;
#(
  parameter int SPB = 60
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  acc_t           totals,
  input  logic [7:0]     block_count,
  input  logic           slot_free,
  output logic           idle,
  output logic           done,
  output result_t        res
);

  localparam int DIV_W = $clog2(255 * SPB + 1);
  localparam int AW    = (DIV_W + 1 > REM_W + 2) ? DIV_W + 1 : REM_W + 2;
  localparam logic [DIV_W-1:0] SPB_C = DIV_W'(SPB);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SETUP    = 3'd1;
  localparam logic [2:0] S_DIV_RMS  = 3'd2;
  localparam logic [2:0] S_SQRT     = 3'd3;
  localparam logic [2:0] S_DIV_MEAN = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  localparam logic [OUT_W-1:0] MEAN_POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] MEAN_NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

  logic [2:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  divisor;
  logic [WORK_W-1:0] work;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  acc_t              win;
  logic [OUT_W-1:0]  rms;
  logic [OUT_W-1:0]  mean;

  logic [7:0]        bc_eff;
  logic [AW-1:0]     op_a;
  logic [AW-1:0]     op_b;
  logic [AW-1:0]     diff;
  logic              ge;
  logic [WORK_W-1:0] quot_next;
  logic [ROOT_W-1:0] root_next;
  logic [SUM_W-1:0]  sum_mag;
  logic              sum_neg;

  sws_sub #(.W(AW)) u_sub (
    .a    (op_a),
    .b    (op_b),
    .diff (diff),
    .ge   (ge)
  );

  always_comb begin
    bc_eff  = (block_count == 8'd0) ? 8'd1 : block_count;
    sum_neg = win.sum[SUM_W-1];
    sum_mag = sum_neg ? (~win.sum + SUM_W'(1)) : win.sum;
    if (state == S_SQRT) begin
      op_a = AW'({rem, work[WORK_W-1 -: 2]});
      op_b = AW'({root, 2'b01});
    end else begin
      op_a = AW'({rem[DIV_W-1:0], work[WORK_W-1]});
      op_b = AW'(divisor);
    end
    quot_next = {work[WORK_W-2:0], ge};
    root_next = {root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          state <= S_DIV_RMS;
          cnt   <= '0;
        end
        S_DIV_RMS: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_SQRT;
            cnt   <= '0;
          end
        end
        S_SQRT: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            state <= S_DIV_MEAN;
            cnt   <= '0;
          end
        end
        S_DIV_MEAN: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          win <= totals;
        end
      end
      S_SETUP: begin
        divisor <= DIV_W'({{(DIV_W-8){1'b0}}, bc_eff} * SPB_C);
        work    <= {win.sq_sum, {(WORK_W-SQ_W){1'b0}}};
        rem     <= '0;
      end
      S_DIV_RMS: begin
        work <= quot_next;
        rem  <= REM_W'(ge ? diff[DIV_W-1:0] : op_a[DIV_W-1:0]);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          rem  <= '0;
          root <= '0;
        end
      end
      S_SQRT: begin
        work <= {work[WORK_W-3:0], 2'b00};
        rem  <= ge ? diff[REM_W-1:0] : op_a[REM_W-1:0];
        root <= root_next;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          rms  <= (|root_next[ROOT_W-1:OUT_W]) ? {OUT_W{1'b1}} : root_next[OUT_W-1:0];
          work <= WORK_W'({sum_mag, 8'h00});
          rem  <= '0;
        end
      end
      S_DIV_MEAN: begin
        work <= quot_next;
        rem  <= REM_W'(ge ? diff[DIV_W-1:0] : op_a[DIV_W-1:0]);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          if (!sum_neg) begin
            mean <= (quot_next > WORK_W'(MEAN_POS_LIM)) ? MEAN_POS_LIM
                                                         : quot_next[OUT_W-1:0];
          end else begin
            mean <= (quot_next > WORK_W'(MEAN_NEG_LIM)) ? MEAN_NEG_LIM
                                                         : (~quot_next[OUT_W-1:0] + OUT_W'(1));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idle          = (state == S_IDLE);
    done          = (state == S_FINISH) && slot_free;
    res.max_value = win.max_value;
    res.min_value = win.min_value;
    res.mean_q8   = $signed(mean);
    res.rms_q8    = rms;
  end

endmodule

// ----- design/sample_window_statistics_unit.sv -----
// Flow: a sample without the last mark is absorbed in the cycle it transfers.
// A sample with the last mark yields its result after its transfer, through a
// setup step, 64 divide steps for the mean square, 32 root steps, 64 divide
// steps for the mean (one shared subtract/compare unit) and one output load.
// Throughput: one sample per cycle while no window close is in flight; input stalls
// in a close, longer while a result waits. Reset (rst, synchronous): block_count = 1.
module sample_window_statistics_unit
  import sws_pkg::*;
#(
  parameter int SAMPLES_PER_BLOCK = 60
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] block_count;
  logic       item_xfer;
  logic       engine_idle;
  logic       engine_done;
  logic       slot_free;
  acc_t       totals;
  result_t    engine_res;

  // Configuration register: user's duty: write only with no window close in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= 8'd1;
    end else if (cfg_we) begin
      block_count <= cfg_wdata;
    end
  end

  // Accept samples whenever the divide/root engine is free; a pending result
  // in the output register does not block accumulation of the next window.
  assign item_ready = engine_idle;
  assign item_xfer  = item_valid && item_ready;

  sws_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .en          (item_xfer),
    .sample      (item.sample),
    .last_sample (item.last_sample),
    .totals      (totals)
  );

  // The engine captures the window totals, including the closing sample,
  // in the cycle that sample transfers.
  sws_engine #(
    .SPB (SAMPLES_PER_BLOCK)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .start       (item_xfer && item.last_sample),
    .totals      (totals),
    .block_count (block_count),
    .slot_free   (slot_free),
    .idle        (engine_idle),
    .done        (engine_done),
    .res         (engine_res)
  );

  // Output register: load when the slot is empty or being drained this cycle.
  assign slot_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (engine_done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Hold the payload until the transfer completes.
  always_ff @(posedge clk) begin
    if (engine_done) begin
      result <= engine_res;
    end
  end

endmodule

// ----- verif/tb_sample_window_statistics_unit.sv -----
`timescale 1ns / 1ps

module tb_sample_window_statistics_unit
  import sws_pkg::*;
;

  localparam int SAMPLES_PER_BLOCK = 60;
  // The limit stays far above any correct run, even if every sample closed a
  // window under the longest gaps and stalls.
  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int CLOSE_LATENCY     = 162;
  localparam int MAX_WAIT          = 13;
  localparam int RANDOM_SAMPLES    = 750;

  // How sample values are drawn for one window.
  typedef enum logic [1:0] {
    MIX_FULL,
    MIX_EDGES,
    MIX_NEAR_ZERO,
    MIX_FLAT
  } mix_t;

  // Tracks the running window statistics and the results still owed by
  // the block, in order of the windows that closed.
  class window_stats_checker;
    result_t              due_results[$];
    logic signed [15:0]   peak_hi;
    logic signed [15:0]   peak_lo;
    logic        [31:0]   total;
    logic        [47:0]   energy;
    bit                   fresh;
    logic        [7:0]    blocks;
    int                   errors;
    int                   checked;

    function new();
      blocks  = 8'd1;
      errors  = 0;
      checked = 0;
      clear_window();
    endfunction

    function void clear_window();
      peak_hi = '0;
      peak_lo = '0;
      total   = '0;
      energy  = '0;
      fresh   = 1'b1;
    endfunction

    function void set_blocks(logic [7:0] v);
      blocks = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    static function bit [63:0] int_root(bit [63:0] x);
      bit [63:0] rest;
      bit [63:0] root;
      bit [63:0] probe;
      rest  = x;
      root  = '0;
      probe = 64'h1 << 62;
      while (probe > rest) probe >>= 2;
      while (probe != 0) begin
        if (rest >= root + probe) begin
          rest = rest - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    // Fold one transferred sample into the window; on the last mark, work
    // out the result the block owes and start a new window.
    function void take_sample(item_t it);
      longint     s;
      longint     divisor;
      longint     mean;
      bit [63:0]  scaled;
      bit [63:0]  root;
      result_t    r;
      s = it.sample;
      if (fresh) begin
        peak_hi = it.sample;
        peak_lo = it.sample;
        fresh   = 1'b0;
      end else begin
        if (it.sample > peak_hi) peak_hi = it.sample;
        if (it.sample < peak_lo) peak_lo = it.sample;
      end
      total  = total + s;
      energy = energy + s * s;
      if (!it.last_sample) return;

      divisor = ((blocks == 0) ? 1 : longint'(blocks)) * SAMPLES_PER_BLOCK;
      mean    = (longint'($signed(total)) * 256) / divisor;
      if (mean > 8388607)  mean = 8388607;
      if (mean < -8388608) mean = -8388608;
      scaled  = {energy, 16'h0000};
      root    = int_root(scaled / 64'(divisor));
      if (root > 64'hFF_FFFF) root = 64'hFF_FFFF;

      r.max_value = peak_hi;
      r.min_value = peak_lo;
      r.mean_q8   = 24'(mean);
      r.rms_q8    = 24'(root);
      due_results.push_back(r);
      clear_window();
    endfunction

    function void compare_field(string label, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      end
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: max %0d min %0d mean %0d rms %0d",
                 $time, got.max_value, got.min_value, got.mean_q8, got.rms_q8);
        return;
      end
      want = due_results.pop_front();
      checked++;
      compare_field("max_value", want.max_value, got.max_value);
      compare_field("min_value", want.min_value, got.min_value);
      compare_field("mean_q8",   want.mean_q8,   got.mean_q8);
      compare_field("rms_q8",    want.rms_q8,    got.rms_q8);
    endfunction

    function void flag_leftovers();
      if (due_results.size() != 0) begin
        errors += due_results.size();
        $display("%0t: %0d expected results never arrived", $time, due_results.size());
      end
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_ready;
  item_t      item         = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result;
  logic       cfg_we       = 1'b0;
  logic [7:0] cfg_wdata    = '0;

  window_stats_checker stats;
  int                  cycle_count  = 0;
  int                  samples_sent = 0;
  // Set for stretches where neither side idles.
  bit                  steady       = 1'b0;

  sample_window_statistics_unit #(
    .SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("tb_sample_window_statistics_unit: errors");
      $finish;
    end
  end

  // Present one sample and hold it until the transfer. Valid is only
  // lowered when an idle gap follows, so back-to-back samples keep it high.
  task automatic send_sample(input logic signed [15:0] s, input bit last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{sample: s, last_sample: last};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    stats.take_sample('{sample: s, last_sample: last});
    samples_sent++;
  endtask

  function automatic logic signed [15:0] pick_sample(mix_t mix, logic signed [15:0] flat);
    logic signed [15:0] v;
    case (mix)
      MIX_FULL: begin
        v = 16'($urandom_range(0, 16'hFFFF));
      end
      MIX_EDGES: begin
        case ($urandom_range(0, 5))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = 16'sh0000;
          3:       v = -16'sd1;
          4:       v = 16'sd1;
          default: v = 16'sh8001;
        endcase
      end
      MIX_NEAR_ZERO: begin
        v = 16'($urandom_range(0, 200)) - 16'sd100;
      end
      default: begin
        v = flat;
      end
    endcase
    return v;
  endfunction

  // Send a whole window; only its final sample carries the last mark.
  task automatic send_window(input int len, input mix_t mix, input logic signed [15:0] flat);
    for (int k = 0; k < len; k++) begin
      send_sample(pick_sample(mix, flat), k == len - 1);
    end
  endtask

  // Drain every owed result, let the block settle, then write block_count.
  task automatic set_block_count(input logic [7:0] v);
    item_valid <= 1'b0;
    while (stats.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stats.set_blocks(v);
  endtask

  // Result side: stall a random number of cycles, then take one transfer.
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      stats.compare_result(result);
    end
  end

  initial begin : stimulus
    int          random_start;
    int          windows;
    logic [7:0]  count_pick;
    stats = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed windows at the reset block count of one.
    send_window(1, MIX_FLAT, 16'sh7FFF);
    send_window(1, MIX_FLAT, 16'sh8000);
    send_window(1, MIX_FLAT, 16'sh0000);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b1);
    // Drive the mean past its top, then past its bottom with the rms
    // beyond 24 bits as well.
    steady = 1'b1;
    send_window(80, MIX_FLAT, 16'sh7FFF);
    send_window(300, MIX_FLAT, 16'sh8000);
    steady = 1'b0;

    // Block count zero behaves as one.
    set_block_count(8'd0);
    send_window(3, MIX_EDGES, '0);
    set_block_count(8'd255);
    send_window(4, MIX_EDGES, '0);

    // Random phases: a block count, then a few complete windows each.
    random_start = samples_sent;
    while (samples_sent - random_start < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 4))
        0:       count_pick = 8'd0;
        1:       count_pick = 8'd1;
        2:       count_pick = 8'd255;
        default: count_pick = 8'($urandom_range(2, 254));
      endcase
      set_block_count(count_pick);
      steady  = ($urandom_range(0, 3) == 0);
      windows = $urandom_range(1, 5);
      repeat (windows) begin
        send_window(($urandom_range(0, 7) == 0) ? $urandom_range(31, 120)
                                                : $urandom_range(1, 30),
                    mix_t'($urandom_range(0, 3)),
                    16'($urandom_range(0, 16'hFFFF)));
      end
      steady = 1'b0;
    end

    // Wait out the last window close, then a latency's worth more.
    item_valid <= 1'b0;
    while (stats.pending() != 0) @(posedge clk);
    repeat (CLOSE_LATENCY + 40) @(posedge clk);
    stats.flag_leftovers();

    $display("Covered %0d samples and %0d window results over block counts 0, 1, 255",
             samples_sent, stats.checked);
    $display("and random ones, incl. saturated mean and rms and stalls on both sides.");
    if (stats.errors == 0) begin
      $display("tb_sample_window_statistics_unit: clean");
    end else begin
      $display("tb_sample_window_statistics_unit: errors");
    end
    $finish;
  end

endmodule
